// ===== rtl/olcs_pkg.sv =====
// Shared constants, types and helpers for the orthogonal Latin cell search block.
// No dependencies; compile first.
package olcs_pkg;

  localparam int ORDER  = 10;
  localparam int CELLS  = ORDER * ORDER;
  localparam int SYM_W  = $clog2(ORDER);
  localparam int IDX_W  = $clog2(ORDER);
  localparam int CELL_W = $clog2(CELLS);

  localparam int CMD_W  = 2;
  localparam int POS_W  = 4;
  localparam int FSYM_W = 4;

  typedef logic [ORDER-1:0] mask_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic capture;
    logic rd;
    logic eval;
    logic upd;
  } dp_cmd_t;

  function automatic logic [SYM_W-1:0] lowest_bit(input mask_t m);
    logic [SYM_W-1:0] res;
    res = '0;
    for (int i = ORDER - 1; i >= 0; i--) begin
      if (m[i]) res = SYM_W'(i);
    end
    return res;
  endfunction

endpackage

// ===== rtl/olcs_if.sv =====
// Valid/ready channel interfaces for the command input and the search result.
// Depends on olcs_pkg for field widths.
interface olcs_in_if;
  logic                        valid;
  logic                        ready;
  logic [olcs_pkg::CMD_W-1:0]  command;
  logic [olcs_pkg::POS_W-1:0]  row;
  logic [olcs_pkg::POS_W-1:0]  column;
  logic [olcs_pkg::FSYM_W-1:0] symbol;

  modport source(output valid, command, row, column, symbol, input ready);
  modport sink(input valid, command, row, column, symbol, output ready);
endinterface

interface olcs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [olcs_pkg::FSYM_W-1:0] placed_symbol;

  modport source(output valid, found, placed_symbol, input ready);
  modport sink(input valid, found, placed_symbol, output ready);
endinterface

// ===== rtl/olcs_ctrl.sv =====
// Sequencer for the cell search: capture, memory read, evaluate, write back.
// Depends on olcs_pkg; drives olcs_dp through dp_cmd_t.
module olcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output olcs_pkg::dp_cmd_t cmd
);
  import olcs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // hold until the result slot is free
        if (!out_valid_r || out_ready) begin
          cmd.upd   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.upd) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/olcs_dp.sv =====
// Datapath: square memories, free-symbol masks, candidate select and mark update.
// Depends on olcs_pkg; sequenced by olcs_ctrl through dp_cmd_t.
module olcs_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  olcs_pkg::dp_cmd_t           cmd,
  input  logic [olcs_pkg::CMD_W-1:0]  in_command,
  input  logic [olcs_pkg::POS_W-1:0]  in_row,
  input  logic [olcs_pkg::POS_W-1:0]  in_column,
  input  logic [olcs_pkg::FSYM_W-1:0] in_symbol,
  output logic                        out_found,
  output logic [olcs_pkg::FSYM_W-1:0] out_placed_symbol
);
  import olcs_pkg::*;

  logic [CMD_W-1:0]  cmd_r;
  logic [POS_W-1:0]  row_r, col_r;
  logic [FSYM_W-1:0] sym_r;

  logic [SYM_W-1:0]  first_mem   [CELLS];
  logic [SYM_W-1:0]  mate_mem    [CELLS];
  mask_t             untried_mem [CELLS];
  logic [CELLS-1:0]  mate_valid_r;

  mask_t             row_free_r  [ORDER];
  mask_t             col_free_r  [ORDER];
  mask_t             pair_free_r [ORDER];
  mask_t             main_free_r, anti_free_r;

  logic [SYM_W-1:0]  first_rd_r, mate_rd_r;
  mask_t             untried_rd_r;
  logic              valid_rd_r;

  logic              found_r, old_v_r;
  logic [SYM_W-1:0]  s_r, old_r, a_r;
  mask_t             untried_eff_r;

  logic              found_o_r;
  logic [FSYM_W-1:0] placed_o_r;

  logic              in_range, on_main, on_anti, is_step, is_clear, is_load;
  logic [IDX_W-1:0]  ri, ci;
  logic [CELL_W-1:0] cell_idx;
  logic [SYM_W-1:0]  a;
  mask_t             untried_eff, cand, sbit, obit;
  logic              upd_marks;

  assign in_range = (int'(row_r) < ORDER) && (int'(col_r) < ORDER);
  assign ri       = row_r[IDX_W-1:0];
  assign ci       = col_r[IDX_W-1:0];
  assign cell_idx = in_range ? CELL_W'(int'(row_r) * ORDER + int'(col_r)) : '0;
  assign on_main  = (row_r == col_r);
  assign on_anti  = (({1'b0, row_r} + {1'b0, col_r}) == (POS_W + 1)'(ORDER - 1));
  assign is_step  = (cmd_r == CMD_STEP);
  assign is_clear = (cmd_r == CMD_CLEAR);
  assign is_load  = (cmd_r == CMD_LOAD);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      row_r <= in_row;
      col_r <= in_column;
      sym_r <= in_symbol;
    end
  end

  // registered memory reads
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      first_rd_r   <= first_mem[cell_idx];
      mate_rd_r    <= mate_mem[cell_idx];
      untried_rd_r <= untried_mem[cell_idx];
      valid_rd_r   <= mate_valid_r[cell_idx];
    end
  end

  always_comb begin
    a           = (int'(first_rd_r) < ORDER) ? first_rd_r : '0;
    untried_eff = valid_rd_r ? untried_rd_r : '1;
    cand        = row_free_r[ri] & col_free_r[ci] & untried_eff & pair_free_r[a];
    if (on_main) cand = cand & main_free_r;
    if (on_anti) cand = cand & anti_free_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      found_r       <= is_step && in_range && (cand != '0);
      old_v_r       <= is_step && in_range && valid_rd_r;
      s_r           <= lowest_bit(cand);
      old_r         <= mate_rd_r;
      a_r           <= a;
      untried_eff_r <= untried_eff;
    end
  end

  assign sbit      = found_r ? (mask_t'(1) << s_r) : '0;
  assign obit      = old_v_r ? (mask_t'(1) << old_r) : '0;
  assign upd_marks = found_r || old_v_r;

  // take the new symbol, free the replaced one; a clear command frees all marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ORDER; k++) begin
        row_free_r[k]  <= '1;
        col_free_r[k]  <= '1;
        pair_free_r[k] <= '1;
      end
      main_free_r  <= '1;
      anti_free_r  <= '1;
      mate_valid_r <= '0;
    end else if (cmd.upd) begin
      if (is_clear) begin
        for (int k = 0; k < ORDER; k++) begin
          row_free_r[k]  <= '1;
          col_free_r[k]  <= '1;
          pair_free_r[k] <= '1;
        end
        main_free_r  <= '1;
        anti_free_r  <= '1;
        mate_valid_r <= '0;
      end else if (upd_marks) begin
        row_free_r[ri]   <= (row_free_r[ri] & ~sbit) | obit;
        col_free_r[ci]   <= (col_free_r[ci] & ~sbit) | obit;
        pair_free_r[a_r] <= (pair_free_r[a_r] & ~sbit) | obit;
        if (on_main) main_free_r <= (main_free_r & ~sbit) | obit;
        if (on_anti) anti_free_r <= (anti_free_r & ~sbit) | obit;
        mate_valid_r[cell_idx] <= found_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && is_load && in_range && (int'(sym_r) < ORDER)) begin
      first_mem[cell_idx] <= sym_r[SYM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && !is_clear && found_r) begin
      mate_mem[cell_idx] <= s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && !is_clear && found_r) begin
      untried_mem[cell_idx] <= untried_eff_r & ~sbit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      found_o_r  <= found_r && !is_clear;
      placed_o_r <= (found_r && !is_clear) ? FSYM_W'(s_r) : '0;
    end
  end

  assign out_found         = found_o_r;
  assign out_placed_symbol = placed_o_r;

endmodule

// ===== rtl/orthogonal_latin_cell_search.sv =====
// Top level of the orthogonal Latin cell search: joins olcs_ctrl and olcs_dp.
// Depends on olcs_pkg, olcs_if, olcs_ctrl and olcs_dp.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    command, row, column, symbol
//   out_chan  out  valid/ready    found, placed_symbol
//
// Every command runs four steps: capture, memory read, evaluate, write back.
// The memory read step is needed because the cell memory reads are registered.
// Reset (rst_n low, synchronous) empties the mate square and frees all marks
// at once; the first square is not cleared.
// A held result stalls only the write-back step; the next command is taken
// while the result waits.
module orthogonal_latin_cell_search (
  input logic       clk,
  input logic       rst_n,
  olcs_in_if.sink   in_chan,
  olcs_out_if.source out_chan
);
  import olcs_pkg::*;

  dp_cmd_t cmd;

  olcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  olcs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_command        (in_chan.command),
    .in_row            (in_chan.row),
    .in_column         (in_chan.column),
    .in_symbol         (in_chan.symbol),
    .out_found         (out_chan.found),
    .out_placed_symbol (out_chan.placed_symbol)
  );

endmodule

// ===== rtl/olcs_checker.sv =====
// Port-level assertions for orthogonal_latin_cell_search, attached by bind.
// Depends on olcs_pkg.
module olcs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        found,
  input logic [olcs_pkg::FSYM_W-1:0] placed_symbol
);
  import olcs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(placed_symbol))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in progress");

  a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 4))
    else $error("result without a command four cycles earlier");

  a_no_symbol_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> placed_symbol == '0)
    else $error("symbol reported without a placement");

  a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> int'(placed_symbol) < ORDER)
    else $error("placed symbol out of range");

endmodule

bind orthogonal_latin_cell_search olcs_checker u_olcs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .found         (out_chan.found),
  .placed_symbol (out_chan.placed_symbol)
);
